// ===== rtl/core/source_text_tokenizer_core_defines.svh =====
// assertion helpers used by the tokenizer rtl
`ifndef SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH

// clocked property check, quiet while reset is held
`define STT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define STT_NEVER(label, clk, rst_n, expr, msg) \
    `STT_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/core/stt_pkg.sv =====
`default_nettype none
package stt_pkg;

    localparam int POS_WIDTH_DEF = 16;

    // scanner modes
    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_IDENT  = 4'd1,
        M_NUMBER = 4'd2,
        M_STRING = 4'd3,
        M_HOLD   = 4'd4,
        M_LINE   = 4'd5,
        M_BLOCK  = 4'd6,
        M_BSTAR  = 4'd7
    } t_mode;

    // operator waiting for its second character
    typedef enum logic [2:0] {
        H_NONE  = 3'd0,
        H_EQ    = 3'd1,
        H_LT    = 3'd2,
        H_GT    = 3'd3,
        H_BANG  = 3'd4,
        H_SLASH = 3'd5
    } t_hold;

    typedef enum logic [4:0] {
        K_END     = 5'd0,
        K_LPAREN  = 5'd1,
        K_RPAREN  = 5'd2,
        K_LBRACE  = 5'd3,
        K_RBRACE  = 5'd4,
        K_COMMA   = 5'd5,
        K_PLUS    = 5'd6,
        K_MINUS   = 5'd7,
        K_STAR    = 5'd8,
        K_SLASH   = 5'd9,
        K_PERCENT = 5'd10,
        K_ASSIGN  = 5'd11,
        K_EQ      = 5'd12,
        K_LT      = 5'd13,
        K_LE      = 5'd14,
        K_GT      = 5'd15,
        K_GE      = 5'd16,
        K_NE      = 5'd17,
        K_IDENT   = 5'd18,
        K_NUMBER  = 5'd19,
        K_STRING  = 5'd20,
        K_ILLEGAL = 5'd21
    } t_kind;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // kind of a held operator when no second character follows
    function automatic t_kind single_kind(input t_hold h);
        case (h)
            H_EQ:    return K_ASSIGN;
            H_LT:    return K_LT;
            H_GT:    return K_GT;
            H_SLASH: return K_SLASH;
            default: return K_ILLEGAL;
        endcase
    endfunction

    // kind of a held operator followed by '='
    function automatic t_kind pair_kind(input t_hold h);
        case (h)
            H_EQ:    return K_EQ;
            H_LT:    return K_LE;
            H_GT:    return K_GE;
            H_BANG:  return K_NE;
            default: return K_ILLEGAL;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/stt_in_if.sv =====
`default_nettype none
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/stt_out_if.sv =====
`default_nettype none
interface stt_out_if #(
    parameter int POS_WIDTH = 16
);
    import stt_pkg::*;

    logic                 valid;
    logic                 ready;
    t_kind                token_kind;
    logic [POS_WIDTH-1:0] token_start;
    logic [POS_WIDTH-1:0] token_length;
    logic                 last_of_item;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_item, input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input last_of_item, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/source_text_tokenizer_core.sv =====
// Streaming tokenizer for source text.
// i_text takes one character per request (text_byte, end_of_text); a zero
// byte or end_of_text ends the input. o_token gives tokens as kind, start
// position and length; last_of_item marks the final token a character caused.
// A character causes zero, one or two tokens.
// A token is offered once the character that completes it has passed the input
// register and been written into the two-entry token queue.
// Throughput: one character per cycle while the receiver takes one token per
// cycle; a character that gives two tokens holds its queue entry until both
// are taken, and a full queue takes a new entry in the cycle its head leaves.
// i_text.ready depends on o_token.ready only while both queue entries are taken.
// When the receiver stalls the queue fills, and i_text.ready drops once both
// entries are taken and the waiting character would add tokens.
// After the end token the block ignores further characters until reset.
// Reset (synchronous, active low) empties the queue, forgets any pending
// token and sets the byte position to zero.
`default_nettype none
`include "source_text_tokenizer_core_defines.svh"
module source_text_tokenizer_core #(
    parameter int POS_WIDTH = stt_pkg::POS_WIDTH_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    stt_in_if.sink    i_text,
    stt_out_if.source o_token
);
    import stt_pkg::*;

    typedef struct packed {
        t_kind                kind;
        logic [POS_WIDTH-1:0] start;
        logic [POS_WIDTH-1:0] len;
    } t_tok;

    localparam logic [1:0]           QDEPTH  = 2'd2;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [POS_WIDTH-1:0] LEN_ONE = POS_WIDTH'(1);
    localparam logic [POS_WIDTH-1:0] LEN_TWO = POS_WIDTH'(2);

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eot;

    // scanner state
    t_mode                r_mode, n_mode;
    t_hold                r_held, n_held;
    logic [POS_WIDTH-1:0] r_origin, n_origin;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic                 r_fin, n_fin;

    // token queue, one entry per character
    t_tok       r_q_tok [2][2];
    logic       r_q_two [2];
    logic [1:0] r_count;
    logic       r_rd, r_wr, r_sub;

    logic                 step_go, push, pop_tok, pop_entry, cont;
    logic [1:0]           step_cnt, fs_cnt;
    t_tok                 tok_a, tok_b, fs_a, fs_b, f_tok, s_tok;
    logic                 f_v, s_v;
    t_mode                s_mode;
    t_hold                s_held;
    logic [POS_WIDTH-1:0] s_origin, span, pos_inc;
    t_tok                 end_tok;

    // position helpers
    always_comb begin
        span    = (r_pos >= r_origin) ? r_pos - r_origin : '0;
        pos_inc = (r_pos == POS_MAX) ? r_pos : r_pos + LEN_ONE;
        end_tok = '{kind: K_END, start: r_pos, len: '0};
    end

    // pending token flushed by a terminating character
    always_comb begin
        f_v   = 1'b0;
        f_tok = '{kind: K_IDENT, start: r_origin, len: span};
        case (r_mode)
            M_IDENT: begin
                f_v = 1'b1;
            end
            M_NUMBER: begin
                f_v        = 1'b1;
                f_tok.kind = K_NUMBER;
            end
            M_STRING: begin
                f_v        = 1'b1;
                f_tok.kind = K_STRING;
            end
            M_HOLD: begin
                f_v        = 1'b1;
                f_tok.kind = single_kind(r_held);
                f_tok.len  = LEN_ONE;
            end
            default: begin
                f_v = 1'b0;
            end
        endcase
    end

    // scan of a character from between tokens
    always_comb begin
        s_v      = 1'b0;
        s_tok    = '{kind: K_ILLEGAL, start: r_pos, len: LEN_ONE};
        s_mode   = M_IDLE;
        s_held   = H_NONE;
        s_origin = r_origin;
        case (r_byte)
            CH_LPAREN: begin s_v = 1'b1; s_tok.kind = K_LPAREN;  end
            CH_RPAREN: begin s_v = 1'b1; s_tok.kind = K_RPAREN;  end
            CH_LBRACE: begin s_v = 1'b1; s_tok.kind = K_LBRACE;  end
            CH_RBRACE: begin s_v = 1'b1; s_tok.kind = K_RBRACE;  end
            CH_COMMA:  begin s_v = 1'b1; s_tok.kind = K_COMMA;   end
            CH_PLUS:   begin s_v = 1'b1; s_tok.kind = K_PLUS;    end
            CH_MINUS:  begin s_v = 1'b1; s_tok.kind = K_MINUS;   end
            CH_STAR:   begin s_v = 1'b1; s_tok.kind = K_STAR;    end
            CH_PCT:    begin s_v = 1'b1; s_tok.kind = K_PERCENT; end
            CH_EQ:     begin s_mode = M_HOLD; s_held = H_EQ;    s_origin = r_pos; end
            CH_LT:     begin s_mode = M_HOLD; s_held = H_LT;    s_origin = r_pos; end
            CH_GT:     begin s_mode = M_HOLD; s_held = H_GT;    s_origin = r_pos; end
            CH_BANG:   begin s_mode = M_HOLD; s_held = H_BANG;  s_origin = r_pos; end
            CH_SLASH:  begin s_mode = M_HOLD; s_held = H_SLASH; s_origin = r_pos; end
            CH_QUOTE: begin
                s_mode   = M_STRING;
                s_origin = pos_inc;
            end
            default: begin
                if (is_space(r_byte)) begin
                    s_v = 1'b0;
                end else if (is_letter(r_byte)) begin
                    s_mode   = M_IDENT;
                    s_origin = r_pos;
                end else if (is_digit(r_byte)) begin
                    s_mode   = M_NUMBER;
                    s_origin = r_pos;
                end else begin
                    s_v = 1'b1;
                end
            end
        endcase
    end

    // flush of the pending token followed by a fresh scan
    always_comb begin
        fs_a   = s_tok;
        fs_b   = s_tok;
        fs_cnt = {1'b0, s_v};
        if (f_v) begin
            fs_a   = f_tok;
            fs_cnt = s_v ? 2'd2 : 2'd1;
        end
    end

    // one step of the scanner on the registered character
    always_comb begin
        n_mode   = r_mode;
        n_held   = r_held;
        n_origin = r_origin;
        n_pos    = r_pos;
        n_fin    = r_fin;
        tok_a    = end_tok;
        tok_b    = end_tok;
        step_cnt = 2'd0;
        cont     = 1'b0;
        if (r_fin) begin
            step_cnt = 2'd0;
        end else if (r_eot || r_byte == CH_NUL) begin
            n_mode = M_IDLE;
            n_held = H_NONE;
            n_fin  = 1'b1;
            if (f_v) begin
                tok_a    = f_tok;
                step_cnt = 2'd2;
            end else begin
                step_cnt = 2'd1;
            end
        end else begin
            n_pos = pos_inc;
            case (r_mode)
                M_IDENT, M_NUMBER: begin
                    cont = (r_mode == M_IDENT) ? is_letter(r_byte) : is_digit(r_byte);
                    if (!cont) begin
                        tok_a    = fs_a;
                        tok_b    = fs_b;
                        step_cnt = fs_cnt;
                        n_mode   = s_mode;
                        n_held   = s_held;
                        n_origin = s_origin;
                    end
                end
                M_STRING: begin
                    if (r_byte == CH_QUOTE) begin
                        tok_a    = f_tok;
                        step_cnt = 2'd1;
                        n_mode   = M_IDLE;
                    end
                end
                M_HOLD: begin
                    if (r_held == H_SLASH && r_byte == CH_SLASH) begin
                        n_mode = M_LINE;
                        n_held = H_NONE;
                    end else if (r_held == H_SLASH && r_byte == CH_STAR) begin
                        n_mode = M_BLOCK;
                        n_held = H_NONE;
                    end else if (r_byte == CH_EQ && (r_held inside {[H_EQ:H_BANG]})) begin
                        tok_a    = '{kind: pair_kind(r_held), start: r_origin, len: LEN_TWO};
                        step_cnt = 2'd1;
                        n_mode   = M_IDLE;
                        n_held   = H_NONE;
                    end else begin
                        tok_a    = fs_a;
                        tok_b    = fs_b;
                        step_cnt = fs_cnt;
                        n_mode   = s_mode;
                        n_held   = s_held;
                        n_origin = s_origin;
                    end
                end
                M_LINE: begin
                    if (r_byte == CH_NL) begin
                        n_mode = M_IDLE;
                    end
                end
                M_BLOCK: begin
                    if (r_byte == CH_STAR) begin
                        n_mode = M_BSTAR;
                    end
                end
                M_BSTAR: begin
                    if (r_byte == CH_SLASH) begin
                        n_mode = M_IDLE;
                    end else if (r_byte != CH_STAR) begin
                        n_mode = M_BLOCK;
                    end
                end
                default: begin
                    tok_a    = fs_a;
                    tok_b    = fs_b;
                    step_cnt = fs_cnt;
                    n_mode   = s_mode;
                    n_held   = s_held;
                    n_origin = s_origin;
                end
            endcase
        end
    end

    // handshake and queue control, a leaving head entry frees its slot
    always_comb begin
        pop_tok        = o_token.valid && o_token.ready;
        pop_entry      = pop_tok && (r_sub || !r_q_two[r_rd]);
        step_go        = r_in_valid &&
                         (step_cnt == 2'd0 || r_count != QDEPTH || pop_entry);
        push           = step_go && step_cnt != 2'd0;
        i_text.ready   = !r_in_valid || step_go;
    end

    // output side of the queue
    always_comb begin
        o_token.valid        = r_count != 2'd0;
        o_token.token_kind   = r_q_tok[r_rd][r_sub].kind;
        o_token.token_start  = r_q_tok[r_rd][r_sub].start;
        o_token.token_length = r_q_tok[r_rd][r_sub].len;
        o_token.last_of_item = r_sub || !r_q_two[r_rd];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.valid && i_text.ready) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
        if (i_text.valid && i_text.ready) begin
            r_byte <= i_text.text_byte;
            r_eot  <= i_text.end_of_text;
        end
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_held   <= H_NONE;
            r_origin <= '0;
            r_pos    <= '0;
            r_fin    <= 1'b0;
        end else if (step_go) begin
            r_mode   <= n_mode;
            r_held   <= n_held;
            r_origin <= n_origin;
            r_pos    <= n_pos;
            r_fin    <= n_fin;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_tok[r_wr][0] <= tok_a;
            r_q_tok[r_wr][1] <= tok_b;
            r_q_two[r_wr]    <= step_cnt == 2'd2;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_count <= r_count + {1'b0, push} - {1'b0, pop_entry};
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop_entry) begin
                r_rd  <= ~r_rd;
                r_sub <= 1'b0;
            end else if (pop_tok) begin
                r_sub <= 1'b1;
            end
        end
    end

    // checks
    `STT_NEVER(a_count_limit, i_clk, i_rst_n, r_count > QDEPTH, "token queue overfilled")
    `STT_ASSERT(a_quiet_after_end, i_clk, i_rst_n, r_fin |-> !push, "token after end of input")
    `STT_ASSERT(a_sub_pair, i_clk, i_rst_n, r_sub |-> (r_q_two[r_rd] && r_count != 2'd0), "second token of a single entry")
    `STT_ASSERT(a_end_last, i_clk, i_rst_n, (o_token.valid && o_token.token_kind == K_END) |-> o_token.last_of_item, "end token not last")

endmodule
`default_nettype wire
